@@ design/longest_window_with_zero_budget_top_assert.svh @@
// Assertion macros for the longest-window block.
// Used by lwzb_ctrl; expects signals named clk and rst in the including scope.
`ifndef LONGEST_WINDOW_WITH_ZERO_BUDGET_TOP_ASSERT_SVH
`define LONGEST_WINDOW_WITH_ZERO_BUDGET_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LWZB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LWZB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lwzb_pkg.sv @@
// Shared types and constants for the longest-window block.
// No dependencies; imported by lwzb_cell, lwzb_ctrl and the top level.
package lwzb_pkg;

  // Parameter defaults
  localparam int MAX_BUDGET_DEF  = 255;
  localparam int LENGTH_BITS_DEF = 16;

  // Fixed field widths
  localparam int BUDGET_W  = 8;
  localparam int OUT_LEN_W = 16;

  // Input beat
  typedef struct packed {
    logic bit_value;
    logic end_of_sequence;
  } sample_t;

  // Output beat
  typedef struct packed {
    logic [OUT_LEN_W-1:0] best_length;
    logic                 final_flag;
  } result_t;

  // Control broadcast to every cell of the zero queue
  typedef struct packed {
    logic step;   // an item is processed: ages advance
    logic shift;  // oldest zero leaves, entries move toward cell 0
    logic load;   // a new zero is written at the load index
  } row_ctrl_t;

endpackage

@@ design/longest_window_with_zero_budget_top.sv @@
// Top level of the longest-window block: control plus a row of queue cells.
// Depends on lwzb_pkg, lwzb_cell and lwzb_ctrl.
//
//  channel | signals                              | direction
//  sample  | sample_valid, sample_ready, sample   | in
//  result  | result_valid, result_ready, result   | out
//  cfg     | cfg_valid, cfg_ready, cfg_data       | in
//
// One sample beat per cycle while sample_ready is high; its result beat sits in
// the output register from the next cycle. The next sample is taken when that
// register is empty or in the cycle its result beat leaves, so beats run back
// to back while result_ready is high. While the budget is below the number of
// kept zeros, sample_ready stays low as the head cell shifts the surplus out
// (at most 255). Reset clears control state only; cell ages need no reset.
module longest_window_with_zero_budget_top #(
  parameter int MAX_BUDGET  = lwzb_pkg::MAX_BUDGET_DEF,
  parameter int LENGTH_BITS = lwzb_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  lwzb_pkg::sample_t             sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lwzb_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lwzb_pkg::BUDGET_W-1:0] cfg_data
);
  import lwzb_pkg::*;

  localparam int CAP   = (MAX_BUDGET < 255) ? MAX_BUDGET : 255;
  localparam int NCELL = CAP + 1;
  localparam int IDX_W = $clog2(CAP + 1);
  localparam int LEN_W = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;

  row_ctrl_t        row_ctrl;
  logic [IDX_W-1:0] load_idx;
  logic [LEN_W-1:0] ages [NCELL];

  // Window control and output register
  lwzb_ctrl #(
    .MAX_BUDGET  (MAX_BUDGET),
    .LENGTH_BITS (LENGTH_BITS),
    .CAP         (CAP),
    .IDX_W       (IDX_W),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .head_age     (ages[0]),
    .row_ctrl     (row_ctrl),
    .load_idx     (load_idx)
  );

  // Row of queue cells, oldest zero at cell 0
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [LEN_W-1:0] up_age;
    if (i == NCELL - 1) begin : g_last
      assign up_age = '0;
    end else begin : g_mid
      assign up_age = ages[i+1];
    end
    lwzb_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (row_ctrl),
      .load_idx (load_idx),
      .up_age   (up_age),
      .age      (ages[i])
    );
  end

endmodule

@@ design/lwzb_cell.sv @@
// One slot of the zero queue: holds the age of one zero.
// Depends on lwzb_pkg; chained in the top level, head at cell 0.
module lwzb_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 8,
  parameter int LEN_W  = 16
) (
  input  logic                clk,
  input  lwzb_pkg::row_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    load_idx,
  input  logic [LEN_W-1:0]    up_age,   // age held by the next cell up the row
  output logic [LEN_W-1:0]    age
);
  import lwzb_pkg::*;

  logic             hit;
  logic [LEN_W-1:0] src;
  logic [LEN_W-1:0] src_inc;

  assign hit     = ctrl.load && (load_idx == IDX_W'(IDX));
  assign src     = ctrl.shift ? up_age : age;
  // saturating age step
  assign src_inc = (src == {LEN_W{1'b1}}) ? src : src + 1'b1;

  // Age register: new zero starts at 0, otherwise own or neighbor's age, +1 on a step
  always_ff @(posedge clk) begin
    if (hit) begin
      age <= '0;
    end else if (ctrl.step) begin
      age <= src_inc;
    end else begin
      age <= src;
    end
  end

endmodule

@@ design/lwzb_ctrl.sv @@
// Window control: budget register, queue fill, window length, best length
// and the output register. Depends on lwzb_pkg and the assertion header.
`include "longest_window_with_zero_budget_top_assert.svh"

module lwzb_ctrl #(
  parameter int MAX_BUDGET  = lwzb_pkg::MAX_BUDGET_DEF,
  parameter int LENGTH_BITS = lwzb_pkg::LENGTH_BITS_DEF,
  parameter int CAP         = (MAX_BUDGET < 255) ? MAX_BUDGET : 255,
  parameter int IDX_W       = $clog2(CAP + 1),
  parameter int LEN_W       = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  lwzb_pkg::sample_t             sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lwzb_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lwzb_pkg::BUDGET_W-1:0] cfg_data,
  input  logic [LEN_W-1:0]              head_age,
  output lwzb_pkg::row_ctrl_t           row_ctrl,
  output logic [IDX_W-1:0]              load_idx
);
  import lwzb_pkg::*;

  logic [BUDGET_W-1:0] budget;
  logic [IDX_W-1:0]    eff_budget;
  logic [IDX_W-1:0]    fill;
  logic [IDX_W-1:0]    fill_next;
  logic [LEN_W-1:0]    win;
  logic [LEN_W-1:0]    win_next;
  logic [LEN_W-1:0]    best;
  logic [LEN_W-1:0]    best_next;
  logic [LEN_W-1:0]    win_inc;
  logic [LEN_W-1:0]    head_inc;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    best_cand;
  logic                trim;
  logic                step;

  // Budget register, clamped to the queue size
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (cfg_valid && cfg_ready) begin
      budget <= cfg_data;
    end
  end

  assign eff_budget = (budget > BUDGET_W'(CAP)) ? IDX_W'(CAP) : IDX_W'(budget);

  // Surplus zeros after a budget decrease leave one per cycle
  assign trim         = fill > eff_budget;
  assign sample_ready = !trim && (!result_valid || result_ready);
  assign step         = sample_valid && sample_ready;

  assign win_inc  = (win == {LEN_W{1'b1}}) ? win : win + 1'b1;
  assign head_inc = (head_age == {LEN_W{1'b1}}) ? head_age : head_age + 1'b1;

  // Next state and queue control
  always_comb begin
    fill_next = fill;
    win_next  = win;
    best_next = best;
    row_ctrl  = '0;
    load_idx  = fill;
    len       = win_inc;
    if (trim) begin
      // window start moves just past the oldest kept zero
      row_ctrl.shift = 1'b1;
      fill_next      = fill - 1'b1;
      win_next       = head_age;
    end else if (step) begin
      row_ctrl.step = 1'b1;
      if (!sample.bit_value) begin
        if (fill == eff_budget) begin
          if (fill == '0) begin
            // no zero allowed: window is empty
            len = '0;
          end else begin
            row_ctrl.shift = 1'b1;
            row_ctrl.load  = 1'b1;
            load_idx       = fill - 1'b1;
            len            = head_inc;
          end
        end else begin
          row_ctrl.load = 1'b1;
          fill_next     = fill + 1'b1;
        end
      end
      if (sample.end_of_sequence) begin
        fill_next = '0;
        win_next  = '0;
        best_next = '0;
      end else begin
        win_next  = len;
        best_next = best_cand;
      end
    end
  end

  assign best_cand = (len > best) ? len : best;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      win  <= '0;
      best <= '0;
    end else begin
      fill <= fill_next;
      win  <= win_next;
      best <= best_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.best_length <= OUT_LEN_W'(best_cand);
      result.final_flag  <= sample.end_of_sequence;
    end
  end

  `LWZB_ASSERT_IMP(a_fill_cap, 1'b1, fill <= IDX_W'(CAP), "queue fill beyond capacity")
  `LWZB_ASSERT_IMP(a_best_ge_win, 1'b1, best >= win, "window longer than best length")
  `LWZB_ASSERT_NXT(a_eos_clear, step && sample.end_of_sequence, fill == '0 && best == '0, "state not cleared at sequence end")
  `LWZB_ASSERT_NXT(a_trim_drop, trim, fill == IDX_W'($past(fill) - 1'b1), "trim did not drop one zero")

endmodule
